/* hw/rtl/lcs_pkg.sv */
`default_nettype none
package lcs_pkg;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned AW      = $clog2(MAX_LEN);
  localparam int unsigned LW      = $clog2(MAX_LEN + 1);
  localparam int unsigned SW      = 7;

  typedef logic [AW-1:0] addr_t;
  typedef logic [LW-1:0] len_t;
  typedef logic [SW-1:0] sym_t;

  localparam logic [1:0] FUNC_APPEND_A = 2'd0;
  localparam logic [1:0] FUNC_APPEND_B = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

  typedef enum logic [1:0] {
    CMP_LT,
    CMP_EQ,
    CMP_GT
  } cmp_res_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ADDR,
    C_CMP,
    C_DONE
  } cmp_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT_OUTER,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_WAIT,
    S_SORT_PUT,
    S_MATCH_OUTER,
    S_MATCH_LD,
    S_MATCH_INNER,
    S_MATCH_WAIT,
    S_EMIT_INIT,
    S_EMIT_LOOP,
    S_EMIT_LD,
    S_EMIT_WAIT,
    S_EMIT_TAKE,
    S_EMIT_FINAL
  } seq_state_e;

  // request to the shared compare unit
  typedef struct packed {
    logic  start;
    logic  ab;     // 1: A against B, 0: A against A
    addr_t p;
    addr_t q;
    len_t  lim;
    len_t  na;
    len_t  nb;
  } cmp_req_t;

  typedef struct packed {
    logic     done;
    cmp_res_e res;
    len_t     len;
  } cmp_rsp_t;

  typedef struct packed {
    logic  we_a;
    logic  we_b;
    addr_t addr;
    sym_t  sym;
  } load_t;

endpackage
`default_nettype wire

/* hw/rtl/lcs_if.sv */
`default_nettype none
interface lcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] symbol;

  modport source (output valid, func, symbol, input ready);
  modport sink (input valid, func, symbol, output ready);
endinterface

interface lcs_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] start_in_a;
  logic [6:0] match_length;
  logic       none_found;
  logic       last;

  modport source (output valid, start_in_a, match_length, none_found, last, input ready);
  modport sink (input valid, start_in_a, match_length, none_found, last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lcs_cmp.sv */
`default_nettype none
module lcs_cmp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lcs_pkg::load_t    load_i,
  input  wire lcs_pkg::cmp_req_t req_i,
  output lcs_pkg::cmp_rsp_t      rsp_o
);
  import lcs_pkg::*;

  sym_t string_a [MAX_LEN];
  sym_t string_b [MAX_LEN];

  cmp_state_e state_q, state_d;
  addr_t      p_q, p_d, q_q, q_d;
  len_t       k_q, k_d, lim_q, lim_d, n1_q, n1_d, n2_q, n2_d;
  logic       ab_q, ab_d;
  cmp_res_e   res_q, res_d;
  sym_t       a_rd_q, b_rd_q;
  logic       rd_en;

  logic [LW:0] pa_sum, qb_sum;
  logic        end_a, end_b, at_lim;

  assign pa_sum = {{(LW+1-AW){1'b0}}, p_q} + {1'b0, k_q};
  assign qb_sum = {{(LW+1-AW){1'b0}}, q_q} + {1'b0, k_q};
  assign end_a  = pa_sum >= {1'b0, n1_q};
  assign end_b  = qb_sum >= {1'b0, n2_q};
  assign at_lim = k_q == lim_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE: if (req_i.start) state_d = C_ADDR;
      C_ADDR: state_d = (end_a || end_b || at_lim) ? C_DONE : C_CMP;
      C_CMP:  state_d = (a_rd_q != b_rd_q) ? C_DONE : C_ADDR;
      C_DONE: state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_comb begin
    p_d   = p_q;
    q_d   = q_q;
    k_d   = k_q;
    lim_d = lim_q;
    n1_d  = n1_q;
    n2_d  = n2_q;
    ab_d  = ab_q;
    res_d = res_q;
    rd_en = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          p_d   = req_i.p;
          q_d   = req_i.q;
          k_d   = '0;
          lim_d = req_i.lim;
          n1_d  = req_i.na;
          n2_d  = req_i.ab ? req_i.nb : req_i.na;
          ab_d  = req_i.ab;
        end
      end
      C_ADDR: begin
        if (at_lim) begin
          res_d = CMP_EQ;
        end else if (end_a && end_b) begin
          res_d = CMP_EQ;
        end else if (end_a) begin
          res_d = CMP_LT;
        end else if (end_b) begin
          res_d = CMP_GT;
        end else begin
          rd_en = 1'b1;
        end
      end
      C_CMP: begin
        if (a_rd_q != b_rd_q) begin
          res_d = (a_rd_q < b_rd_q) ? CMP_LT : CMP_GT;
        end else begin
          k_d = len_t'(k_q + len_t'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i.we_a) string_a[load_i.addr] <= load_i.sym;
    if (load_i.we_b) string_b[load_i.addr] <= load_i.sym;
    if (rd_en) begin
      a_rd_q <= string_a[pa_sum[AW-1:0]];
      b_rd_q <= ab_q ? string_b[qb_sum[AW-1:0]] : string_a[qb_sum[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    q_q   <= q_d;
    k_q   <= k_d;
    lim_q <= lim_d;
    n1_q  <= n1_d;
    n2_q  <= n2_d;
    ab_q  <= ab_d;
    res_q <= res_d;
  end

  assign rsp_o.done = state_q == C_DONE;
  assign rsp_o.res  = res_q;
  assign rsp_o.len  = k_q;

endmodule
`default_nettype wire

/* hw/rtl/lcs_seq.sv */
`default_nettype none
module lcs_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  lcs_in_if.sink                 in_i,
  lcs_out_if.source              out_o,
  output lcs_pkg::load_t         load_o,
  output lcs_pkg::cmp_req_t      cmp_req_o,
  input  wire lcs_pkg::cmp_rsp_t cmp_rsp_i
);
  import lcs_pkg::*;

  addr_t sa_mem  [MAX_LEN];
  addr_t ans_mem [MAX_LEN];

  seq_state_e state_q, state_d;
  len_t  i_q, i_d, k_q, k_d, j_q, j_d, m_q, m_d;
  len_t  na_q, na_d, nb_q, nb_d, best_q, best_d, cnt_q, cnt_d;
  addr_t pa_q, pa_d, prev_q, prev_d, cur_q, cur_d, pend_q, pend_d;
  logic  have_pend_q, have_pend_d;

  logic  out_valid_q, out_valid_d, out_last_q, out_last_d, out_none_q, out_none_d;
  addr_t out_start_q, out_start_d;
  len_t  out_len_q, out_len_d;
  logic  out_free, accept;

  logic  sa_we, sa_re, ans_we, ans_re;
  addr_t sa_waddr, sa_wdata, sa_raddr, ans_waddr, ans_wdata, ans_raddr;
  addr_t sa_rd_q, ans_rd_q;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:        if (accept && in_i.func == FUNC_COMPUTE) state_d = S_SORT_OUTER;
      S_SORT_OUTER: begin
        if (i_q == na_q)      state_d = S_MATCH_OUTER;
        else if (i_q == '0)   state_d = S_SORT_PUT;
        else                  state_d = S_SORT_RD;
      end
      S_SORT_RD:     state_d = S_SORT_CMP;
      S_SORT_CMP:    state_d = S_SORT_WAIT;
      S_SORT_WAIT: begin
        if (cmp_rsp_i.done) begin
          if (cmp_rsp_i.res == CMP_GT && k_q != len_t'(1)) state_d = S_SORT_RD;
          else                                             state_d = S_SORT_PUT;
        end
      end
      S_SORT_PUT:    state_d = S_SORT_OUTER;
      S_MATCH_OUTER: state_d = (i_q == na_q) ? S_EMIT_INIT : S_MATCH_LD;
      S_MATCH_LD:    state_d = S_MATCH_INNER;
      S_MATCH_INNER: state_d = (j_q == nb_q) ? S_MATCH_OUTER : S_MATCH_WAIT;
      S_MATCH_WAIT:  if (cmp_rsp_i.done) state_d = S_MATCH_INNER;
      S_EMIT_INIT:   state_d = (best_q == '0) ? S_EMIT_FINAL : S_EMIT_LOOP;
      S_EMIT_LOOP:   state_d = (i_q == cnt_q) ? S_EMIT_FINAL : S_EMIT_LD;
      S_EMIT_LD:     state_d = (i_q == '0) ? S_EMIT_TAKE : S_EMIT_WAIT;
      S_EMIT_WAIT: begin
        if (cmp_rsp_i.done) begin
          state_d = (cmp_rsp_i.res == CMP_EQ) ? S_EMIT_LOOP : S_EMIT_TAKE;
        end
      end
      S_EMIT_TAKE:   if (!have_pend_q || out_free) state_d = S_EMIT_LOOP;
      S_EMIT_FINAL:  if (out_free) state_d = S_IDLE;
      default:       state_d = S_IDLE;
    endcase
  end

  always_comb begin
    i_d = i_q; k_d = k_q; j_d = j_q; m_d = m_q;
    na_d = na_q; nb_d = nb_q; best_d = best_q; cnt_d = cnt_q;
    pa_d = pa_q; prev_d = prev_q; cur_d = cur_q; pend_d = pend_q;
    have_pend_d = have_pend_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_last_d = out_last_q; out_none_d = out_none_q;
    out_start_d = out_start_q; out_len_d = out_len_q;
    sa_we = 1'b0; sa_re = 1'b0; ans_we = 1'b0; ans_re = 1'b0;
    sa_waddr = k_q[AW-1:0]; sa_wdata = sa_rd_q; sa_raddr = i_q[AW-1:0];
    ans_waddr = cnt_q[AW-1:0]; ans_wdata = pa_q; ans_raddr = i_q[AW-1:0];
    load_o = '0;
    load_o.sym = in_i.symbol;
    cmp_req_o = '0;
    cmp_req_o.na = na_q;
    cmp_req_o.nb = nb_q;
    cmp_req_o.lim = len_t'(MAX_LEN);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_i.func)
            FUNC_APPEND_A: begin
              if (na_q < len_t'(MAX_LEN)) begin
                load_o.we_a = 1'b1;
                load_o.addr = na_q[AW-1:0];
                na_d = len_t'(na_q + len_t'(1));
              end
            end
            FUNC_APPEND_B: begin
              if (nb_q < len_t'(MAX_LEN)) begin
                load_o.we_b = 1'b1;
                load_o.addr = nb_q[AW-1:0];
                nb_d = len_t'(nb_q + len_t'(1));
              end
            end
            FUNC_COMPUTE: i_d = '0;
            default: ;
          endcase
        end
      end
      S_SORT_OUTER: begin
        k_d = i_q;
        if (i_q == na_q) begin
          i_d = '0;
          best_d = '0;
          cnt_d = '0;
        end
      end
      S_SORT_RD: begin
        sa_re = 1'b1;
        sa_raddr = addr_t'(k_q - len_t'(1));
      end
      S_SORT_CMP: begin
        cmp_req_o.start = 1'b1;
        cmp_req_o.p = sa_rd_q;
        cmp_req_o.q = i_q[AW-1:0];
      end
      S_SORT_WAIT: begin
        // shift the larger suffix up one slot
        if (cmp_rsp_i.done && cmp_rsp_i.res == CMP_GT) begin
          sa_we = 1'b1;
          k_d = len_t'(k_q - len_t'(1));
        end
      end
      S_SORT_PUT: begin
        sa_we = 1'b1;
        sa_wdata = i_q[AW-1:0];
        i_d = len_t'(i_q + len_t'(1));
      end
      S_MATCH_OUTER: begin
        sa_re = 1'b1;
      end
      S_MATCH_LD: begin
        pa_d = sa_rd_q;
        j_d = '0;
        m_d = '0;
      end
      S_MATCH_INNER: begin
        if (j_q == nb_q) begin
          i_d = len_t'(i_q + len_t'(1));
          if (m_q > best_q) begin
            best_d = m_q;
            ans_we = 1'b1;
            ans_waddr = '0;
            cnt_d = len_t'(1);
          end else if (m_q != '0 && m_q == best_q) begin
            ans_we = 1'b1;
            cnt_d = len_t'(cnt_q + len_t'(1));
          end
        end else begin
          cmp_req_o.start = 1'b1;
          cmp_req_o.ab = 1'b1;
          cmp_req_o.p = pa_q;
          cmp_req_o.q = j_q[AW-1:0];
        end
      end
      S_MATCH_WAIT: begin
        if (cmp_rsp_i.done) begin
          if (cmp_rsp_i.len > m_q) m_d = cmp_rsp_i.len;
          j_d = len_t'(j_q + len_t'(1));
        end
      end
      S_EMIT_INIT: begin
        i_d = '0;
        have_pend_d = 1'b0;
      end
      S_EMIT_LOOP: begin
        ans_re = 1'b1;
      end
      S_EMIT_LD: begin
        cur_d = ans_rd_q;
        // same leading best symbols as the previous candidate means same substring
        cmp_req_o.start = i_q != '0;
        cmp_req_o.p = prev_q;
        cmp_req_o.q = ans_rd_q;
        cmp_req_o.lim = best_q;
      end
      S_EMIT_WAIT: begin
        if (cmp_rsp_i.done) begin
          prev_d = cur_q;
          if (cmp_rsp_i.res == CMP_EQ) i_d = len_t'(i_q + len_t'(1));
        end
      end
      S_EMIT_TAKE: begin
        if (!have_pend_q || out_free) begin
          if (have_pend_q) begin
            out_valid_d = 1'b1;
            out_start_d = pend_q;
            out_len_d = best_q;
            out_none_d = 1'b0;
            out_last_d = 1'b0;
          end
          pend_d = cur_q;
          prev_d = cur_q;
          have_pend_d = 1'b1;
          i_d = len_t'(i_q + len_t'(1));
        end
      end
      S_EMIT_FINAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d = 1'b1;
          out_len_d = best_q;
          out_none_d = best_q == '0;
          out_start_d = (best_q == '0) ? '0 : pend_q;
          na_d = '0;
          nb_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sa_we) sa_mem[sa_waddr] <= sa_wdata;
    if (sa_re) sa_rd_q <= sa_mem[sa_raddr];
    if (ans_we) ans_mem[ans_waddr] <= ans_wdata;
    if (ans_re) ans_rd_q <= ans_mem[ans_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      na_q        <= '0;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
      have_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      na_q        <= na_d;
      nb_q        <= nb_d;
      out_valid_q <= out_valid_d;
      have_pend_q <= have_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; k_q <= k_d; j_q <= j_d; m_q <= m_d;
    best_q <= best_d; cnt_q <= cnt_d;
    pa_q <= pa_d; prev_q <= prev_d; cur_q <= cur_d; pend_q <= pend_d;
    out_last_q <= out_last_d; out_none_q <= out_none_d;
    out_start_q <= out_start_d; out_len_q <= out_len_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.start_in_a   = out_start_q;
  assign out_o.match_length = out_len_q;
  assign out_o.none_found   = out_none_q;
  assign out_o.last         = out_last_q;

`ifndef ASSERT_OFF
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_none_q |-> out_last_q && out_len_q == '0)
    else $error("none_found word not final or has a length");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT_LOOP |-> cnt_q <= na_q)
    else $error("candidate count exceeds string length");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    na_q <= len_t'(MAX_LEN) && nb_q <= len_t'(MAX_LEN))
    else $error("string length beyond capacity");
`endif

endmodule
`default_nettype wire

/* hw/rtl/longest_common_substrings_core.sv */
// channel | dir | words
// in_i    | in  | func, symbol: append to A or B, or compute
// out_o   | out | start_in_a, match_length, none_found, last
// an append is accepted in idle and keeps in_i.ready high; a compute holds in_i.ready low until its last word is queued
// compute time is set by one shared compare unit walking the strings symbol by symbol
// sort: up to na*(na-1)/2 suffix compares; match: na*nb prefix walks; dedup: one walk per candidate after the first
// reset clears lengths and control; string and list memories are undefined until written
// a stalled out_o holds its word; the compute waits only when the next word must be queued
`default_nettype none
module longest_common_substrings_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lcs_in_if.sink    in_i,
  lcs_out_if.source out_o
);
  import lcs_pkg::*;

  load_t    load;
  cmp_req_t cmp_req;
  cmp_rsp_t cmp_rsp;

  lcs_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .load_o    (load),
    .cmp_req_o (cmp_req),
    .cmp_rsp_i (cmp_rsp)
  );

  lcs_cmp u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .req_i  (cmp_req),
    .rsp_o  (cmp_rsp)
  );

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
  import lcs_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         IDLE_LIMIT  = 2000000;
  localparam int         LONG_HOLD   = 400;

  typedef struct packed {
    logic [5:0] start;
    logic [6:0] mlen;
    logic       none;
    logic       last;
  } lcs_word_t;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] sym;
    logic       typed;
    lcs_word_t  word;
  } stim_row_t;

  logic clk;
  logic rst_n;

  lcs_in_if  in_if ();
  lcs_out_if out_if ();

  longest_common_substrings_core u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // predictor state
  logic [6:0] str_a [MAX_LEN];
  logic [6:0] str_b [MAX_LEN];
  int         len_a;
  int         len_b;
  lcs_word_t  substr_q [$];

  int  sent;
  int  fails;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  function automatic int suffix_order(int i, int j);
    while (i < len_a && j < len_a) begin
      if (str_a[i] != str_a[j]) return (str_a[i] < str_a[j]) ? -1 : 1;
      i++;
      j++;
    end
    if (i >= len_a && j >= len_a) return 0;
    return (i >= len_a) ? -1 : 1;
  endfunction

  function automatic int shared_run(int pa, int pb);
    int k;
    k = 0;
    while (pa + k < len_a && pb + k < len_b && str_a[pa+k] == str_b[pb+k]) k++;
    return k;
  endfunction

  // apply one word to the predictor, queue its substrings when asked
  function automatic void predict_word(logic [1:0] func, logic [6:0] sym, bit keep);
    int        ord [MAX_LEN];
    int        cand [$];
    int        best;
    int        m;
    int        k;
    int        v;
    bit        same;
    lcs_word_t w;
    if (func == FUNC_APPEND_A) begin
      if (len_a < MAX_LEN) begin
        str_a[len_a] = sym;
        len_a++;
      end
      return;
    end
    if (func == FUNC_APPEND_B) begin
      if (len_b < MAX_LEN) begin
        str_b[len_b] = sym;
        len_b++;
      end
      return;
    end
    if (func != FUNC_COMPUTE) return;
    for (int i = 0; i < len_a; i++) begin
      v = i;
      k = i;
      while (k > 0 && suffix_order(ord[k-1], v) > 0) begin
        ord[k] = ord[k-1];
        k--;
      end
      ord[k] = v;
    end
    best = 0;
    for (int i = 0; i < len_a; i++) begin
      m = 0;
      for (int j = 0; j < len_b; j++) begin
        k = shared_run(ord[i], j);
        if (k > m) m = k;
      end
      if (m > best) begin
        best = m;
        cand.delete();
        cand.push_back(ord[i]);
      end else if (m != 0 && m == best) begin
        cand.push_back(ord[i]);
      end
    end
    if (keep) begin
      if (best == 0) begin
        w = '{start: '0, mlen: '0, none: 1'b1, last: 1'b1};
        substr_q.push_back(w);
      end else begin
        for (int i = 0; i < cand.size(); i++) begin
          same = 1'b0;
          if (i > 0) begin
            same = 1'b1;
            for (int t = 0; t < best; t++)
              if (str_a[cand[i-1]+t] != str_a[cand[i]+t]) same = 1'b0;
          end
          if (!same) begin
            w = '{start: cand[i][5:0], mlen: best[6:0], none: 1'b0, last: 1'b0};
            substr_q.push_back(w);
          end
        end
        substr_q[substr_q.size()-1].last = 1'b1;
      end
    end
    len_a = 0;
    len_b = 0;
  endfunction

  function automatic int draw_gap();
    if ((sent / 60) % 4 == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic send_word(logic [1:0] func, logic [6:0] sym, bit typed, lcs_word_t w);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.func   <= func;
    in_if.symbol <= sym;
    do @(posedge clk); while (!in_if.ready);
    if (typed) begin
      predict_word(func, sym, 1'b0);
      substr_q.push_back(w);
    end else begin
      predict_word(func, sym, 1'b1);
    end
    sent++;
  endtask

  task automatic send_plain(logic [1:0] func, logic [6:0] sym);
    send_word(func, sym, 1'b0, '0);
  endtask

  // word sink with random stalls and one long hold
  initial begin
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (hold_req) begin
        gap = LONG_HOLD;
        hold_req = 1'b0;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  always @(posedge clk) begin
    lcs_word_t got;
    lcs_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{start: out_if.start_in_a, mlen: out_if.match_length,
              none: out_if.none_found, last: out_if.last};
      if (substr_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected word start=%0d len=%0d none=%0b last=%0b",
                                  got.start, got.mlen, got.none, got.last);
      end else begin
        want = substr_q.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10)
            $display({"word mismatch: exp start=%0d len=%0d none=%0b last=%0b, ",
                      "got start=%0d len=%0d none=%0b last=%0b"},
                     want.start, want.mlen, want.none, want.last,
                     got.start, got.mlen, got.none, got.last);
        end
      end
    end
  end

  // watchdog on handshake activity
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("longest_common_substrings_core: mismatch");
        $finish;
      end
    end
  end

  stim_row_t dir_rows [] = '{
    '{FUNC_COMPUTE,  7'd0,   1'b1, '{6'd0, 7'd0, 1'b1, 1'b1}},
    '{FUNC_APPEND_A, 7'd5,   1'b0, '0},
    '{FUNC_APPEND_B, 7'd5,   1'b0, '0},
    '{FUNC_COMPUTE,  7'd99,  1'b1, '{6'd0, 7'd1, 1'b0, 1'b1}},
    '{FUNC_APPEND_A, 7'd127, 1'b0, '0},
    '{FUNC_APPEND_B, 7'd0,   1'b0, '0},
    '{FUNC_COMPUTE,  7'd127, 1'b1, '{6'd0, 7'd0, 1'b1, 1'b1}},
    '{FUNC_UNUSED,   7'd85,  1'b0, '0},
    '{FUNC_APPEND_A, 7'd42,  1'b0, '0},
    '{FUNC_COMPUTE,  7'd42,  1'b1, '{6'd0, 7'd0, 1'b1, 1'b1}},
    '{FUNC_APPEND_A, 7'd1,   1'b0, '0},
    '{FUNC_APPEND_A, 7'd2,   1'b0, '0},
    '{FUNC_APPEND_A, 7'd1,   1'b0, '0},
    '{FUNC_APPEND_A, 7'd2,   1'b0, '0},
    '{FUNC_APPEND_B, 7'd2,   1'b0, '0},
    '{FUNC_APPEND_B, 7'd1,   1'b0, '0},
    '{FUNC_APPEND_B, 7'd2,   1'b0, '0},
    '{FUNC_COMPUTE,  7'd0,   1'b0, '0},
    '{FUNC_APPEND_A, 7'd0,   1'b0, '0},
    '{FUNC_APPEND_A, 7'd0,   1'b0, '0},
    '{FUNC_APPEND_B, 7'd0,   1'b0, '0},
    '{FUNC_UNUSED,   7'd0,   1'b0, '0},
    '{FUNC_COMPUTE,  7'd0,   1'b0, '0}
  };

  initial begin
    int        la;
    int        lb;
    int        asz;
    int        base;
    int        chunk;
    logic [6:0] qa [$];
    logic [6:0] qb [$];
    sent         = 0;
    fails        = 0;
    hold_req     = 1'b0;
    len_a        = 0;
    len_b        = 0;
    in_if.valid  = 1'b0;
    in_if.func   = FUNC_APPEND_A;
    in_if.symbol = '0;
    @(posedge rst_n);

    foreach (dir_rows[i])
      send_word(dir_rows[i].func, dir_rows[i].sym, dir_rows[i].typed, dir_rows[i].word);

    // both strings past capacity, with a shared run copied from A into B
    for (int i = 0; i < MAX_LEN + 4; i++) send_plain(FUNC_APPEND_A, 7'($urandom_range(0, 127)));
    chunk = $urandom_range(0, 50);
    for (int i = 0; i < MAX_LEN + 3; i++)
      send_plain(FUNC_APPEND_B, (i >= 20 && i < 30) ? str_a[chunk + i - 20]
                                                    : 7'($urandom_range(0, 127)));
    send_plain(FUNC_COMPUTE, 7'($urandom_range(0, 127)));

    // many one-symbol substrings while the sink holds off
    for (int i = 1; i <= 40; i++) send_plain(FUNC_APPEND_A, 7'(i));
    for (int i = 40; i >= 1; i--) send_plain(FUNC_APPEND_B, 7'(i));
    hold_req = 1'b1;
    send_plain(FUNC_COMPUTE, 7'd0);
    for (int i = 0; i < 6; i++) send_plain(FUNC_APPEND_A, 7'($urandom_range(0, 127)));
    send_plain(FUNC_COMPUTE, 7'd0);

    // sender pause until the sink has drained everything
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (substr_q.size() != 0) @(posedge clk);

    while (sent < 500) begin
      if ($urandom_range(0, 9) < 8) begin
        la   = ($urandom_range(0, 30) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 12);
        lb   = ($urandom_range(0, 30) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 12);
        asz  = (la > 16 || lb > 16) ? $urandom_range(3, 127) : $urandom_range(1, 4);
        base = $urandom_range(0, 128 - asz);
        qa.delete();
        qb.delete();
        for (int i = 0; i < la; i++) qa.push_back(7'(base + $urandom_range(0, asz - 1)));
        for (int i = 0; i < lb; i++) qb.push_back(7'(base + $urandom_range(0, asz - 1)));
        while (qa.size() != 0 || qb.size() != 0) begin
          if ($urandom_range(0, 20) == 0)
            send_plain(FUNC_UNUSED, 7'($urandom_range(0, 127)));
          else if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1)))
            send_plain(FUNC_APPEND_A, qa.pop_front());
          else
            send_plain(FUNC_APPEND_B, qb.pop_front());
        end
        send_plain(FUNC_COMPUTE, 7'($urandom_range(0, 127)));
      end else begin
        send_plain(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
      end
    end
    send_plain(FUNC_COMPUTE, 7'd0);

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (substr_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) $display("longest_common_substrings_core: match");
    else $display("longest_common_substrings_core: mismatch");
    $finish;
  end

endmodule
